>>> src/mdq_pkg.sv
// Shared types and constants for the media blocking request queue.
`timescale 1ns / 1ps
package mdq_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int ID_WIDTH    = 16;
   localparam int TAG_WIDTH   = 16;
   localparam int IDX_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [2:0] MODE_ENQUEUE  = 3'd0;
   localparam logic [2:0] MODE_ISSUE    = 3'd1;
   localparam logic [2:0] MODE_COMPLETE = 3'd2;
   localparam logic [2:0] MODE_FAIL     = 3'd3;
   localparam logic [2:0] MODE_SET_TAG  = 3'd4;
   localparam logic [2:0] MODE_DISABLE  = 3'd5;
   localparam logic [2:0] MODE_ENABLE   = 3'd6;

   localparam logic [2:0] KIND_ACCEPTED = 3'd0;
   localparam logic [2:0] KIND_REJECTED = 3'd1;
   localparam logic [2:0] KIND_DROPPED  = 3'd2;
   localparam logic [2:0] KIND_ISSUED   = 3'd3;
   localparam logic [2:0] KIND_NONE     = 3'd4;
   localparam logic [2:0] KIND_CANCEL   = 3'd5;
   localparam logic [2:0] KIND_ACK      = 3'd6;

   typedef struct packed {
      logic [ID_WIDTH-1:0]  id;
      logic [TAG_WIDTH-1:0] tag;
      logic                 has_tag;
      logic                 audio;
      logic                 visual;
      logic                 blocking;
   } entry_type;

   typedef struct packed {
      logic                 all;
      logic                 has_tag;
      logic [TAG_WIDTH-1:0] tag;
      logic [ID_WIDTH-1:0]  id;
      logic                 blk_audio;
      logic                 blk_visual;
   } match_ctl_type;

   typedef struct packed {
      logic scrub_hit;
      logic id_hit;
      logic blocked;
   } match_res_type;

endpackage

>>> src/mdq_match.sv
// Shared compare unit: tests one queue entry against the current target.
`timescale 1ns / 1ps
module mdq_match (
   input  mdq_pkg::entry_type     ent,
   input  mdq_pkg::match_ctl_type ctl,
   output mdq_pkg::match_res_type res
);

   always_comb begin
      res.scrub_hit = ctl.all || (ctl.has_tag && ent.has_tag && (ent.tag == ctl.tag));
      res.id_hit    = (ent.id == ctl.id);
      res.blocked   = (ent.audio && ctl.blk_audio) || (ent.visual && ctl.blk_visual);
   end

endmodule

>>> src/media_blocking_directive_queue.sv
// Top level: media blocking request queue with a walking sequencer.
//
//  channel   ports                      handshake
//  request   req_*                      start high while busy low
//  result    rsp_*                      rsp_valid strobe, one cycle per beat
//
// Enqueue, enable and unused modes: result the cycle after start, no busy time.
// Issue: walks the entries to the first unblocked one, then shifts the later ones down.
// Complete: id pass. Fail: id pass, count pass, two holder steps, scrub pass. Tag change,
// disable: count pass, two holder steps, scrub pass. All walks use the one compare unit.
// Reset is synchronous; the queue is empty and enabled after it. Results cannot stall.
`timescale 1ns / 1ps
module media_blocking_directive_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [2:0]                    req_mode,
   input  logic [mdq_pkg::ID_WIDTH-1:0]  req_request_id,
   input  logic [mdq_pkg::TAG_WIDTH-1:0] req_group_tag,
   input  logic                          req_has_group_tag,
   input  logic                          req_bypass_tag_check,
   input  logic                          req_prehandle_ok,
   input  logic                          req_uses_audio,
   input  logic                          req_uses_visual,
   input  logic                          req_is_blocking,
   output logic                          rsp_valid,
   output logic [2:0]                    rsp_kind,
   output logic [mdq_pkg::ID_WIDTH-1:0]  rsp_out_id,
   output logic                          rsp_last,
   output logic [4:0]                    rsp_queue_count
);

   typedef enum logic [2:0] {
      S_IDLE, S_ISSUE, S_SHIFT, S_REMOVE, S_COUNT, S_HOLD_A, S_HOLD_V, S_SCRUB
   } state_type;

   localparam int IW = mdq_pkg::ID_WIDTH;
   localparam int TW = mdq_pkg::TAG_WIDTH;
   localparam int XW = mdq_pkg::IDX_W;
   localparam int CW = mdq_pkg::CNT_W;

   state_type           state_ff;
   mdq_pkg::entry_type  store_ff [mdq_pkg::QUEUE_DEPTH];
   logic [CW-1:0]       count_ff, rd_ff, wr_ff, surv_ff, removed_ff;
   logic [2:0]          mode_ff;
   logic [IW-1:0]       id_ff;
   logic                all_ff, has_ff, any_ff, freed_a_ff, ba_ff, bv_ff;
   logic [TW-1:0]       tag_ff;
   logic [IW-1:0]       aid_ff;
   logic                new_has_ff;
   logic [TW-1:0]       new_tag_ff;
   logic                a_valid_ff, v_valid_ff, a_has_ff, v_has_ff;
   logic [IW-1:0]       a_id_ff, v_id_ff;
   logic [TW-1:0]       a_tag_ff, v_tag_ff;
   logic                grp_present_ff, enabled_ff;
   logic [TW-1:0]       grp_tag_ff;
   logic                rsp_valid_ff, rsp_last_ff;
   logic [2:0]          rsp_kind_ff;
   logic [IW-1:0]       rsp_id_ff;
   logic [CW-1:0]       rsp_count_ff;

   mdq_pkg::entry_type     cur_ent;
   mdq_pkg::match_ctl_type mctl;
   mdq_pkg::match_res_type mres;
   logic [TW-1:0]          in_tag;
   logic                   a_hit, v_hit, v_cancel, tag_change, drop;
   logic [CW-1:0]          rd_next;

   assign cur_ent = store_ff[rd_ff[XW-1:0]];
   assign rd_next = rd_ff + 1'b1;
   assign in_tag  = req_has_group_tag ? req_group_tag : '0;

   always_comb begin
      mctl.all        = all_ff;
      mctl.has_tag    = has_ff;
      mctl.tag        = tag_ff;
      mctl.id         = id_ff;
      mctl.blk_audio  = ba_ff;
      mctl.blk_visual = bv_ff;
   end

   mdq_match u_match (.ent(cur_ent), .ctl(mctl), .res(mres));

   assign a_hit = a_valid_ff && (all_ff || (has_ff && a_has_ff && a_tag_ff == tag_ff));
   assign v_hit = v_valid_ff && (all_ff || (has_ff && v_has_ff && v_tag_ff == tag_ff));
   assign v_cancel = v_hit && !(a_hit && v_id_ff == a_id_ff);
   assign tag_change = (req_has_group_tag != grp_present_ff) ||
                       (req_has_group_tag && in_tag != grp_tag_ff);
   assign drop = !req_bypass_tag_check && req_has_group_tag &&
                 (!grp_present_ff || grp_tag_ff != in_tag);

   always_ff @(posedge clock) begin
      rsp_valid_ff <= 1'b0;
      if (reset) begin
         state_ff       <= S_IDLE;
         count_ff       <= '0;
         a_valid_ff     <= 1'b0;
         v_valid_ff     <= 1'b0;
         grp_present_ff <= 1'b0;
         grp_tag_ff     <= '0;
         enabled_ff     <= 1'b1;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (start) begin
                  mode_ff    <= req_mode;
                  id_ff      <= req_request_id;
                  new_has_ff <= req_has_group_tag;
                  new_tag_ff <= in_tag;
                  rd_ff      <= '0;
                  wr_ff      <= '0;
                  surv_ff    <= '0;
                  any_ff     <= 1'b0;
                  all_ff     <= 1'b0;
                  rsp_id_ff  <= '0;
                  rsp_last_ff <= 1'b1;
                  rsp_count_ff <= count_ff;
                  case (req_mode)
                     mdq_pkg::MODE_ENQUEUE: begin
                        rsp_valid_ff <= 1'b1;
                        if (!enabled_ff || (!drop && !req_prehandle_ok) ||
                            (!drop && count_ff >= CW'(mdq_pkg::QUEUE_DEPTH))) begin
                           rsp_kind_ff <= mdq_pkg::KIND_REJECTED;
                        end else if (drop) begin
                           rsp_kind_ff <= mdq_pkg::KIND_DROPPED;
                        end else begin
                           rsp_kind_ff <= mdq_pkg::KIND_ACCEPTED;
                           store_ff[count_ff[XW-1:0]] <= '{id: req_request_id, tag: in_tag,
                              has_tag: req_has_group_tag, audio: req_uses_audio,
                              visual: req_uses_visual, blocking: req_is_blocking};
                           count_ff     <= count_ff + 1'b1;
                           rsp_count_ff <= count_ff + 1'b1;
                        end
                     end
                     mdq_pkg::MODE_ISSUE: begin
                        ba_ff    <= a_valid_ff;
                        bv_ff    <= v_valid_ff;
                        state_ff <= S_ISSUE;
                     end
                     mdq_pkg::MODE_COMPLETE, mdq_pkg::MODE_FAIL: begin
                        if (a_valid_ff && a_id_ff == req_request_id) a_valid_ff <= 1'b0;
                        if (v_valid_ff && v_id_ff == req_request_id) v_valid_ff <= 1'b0;
                        state_ff <= S_REMOVE;
                     end
                     mdq_pkg::MODE_SET_TAG: begin
                        if (tag_change) begin
                           has_ff   <= grp_present_ff;
                           tag_ff   <= grp_tag_ff;
                           state_ff <= S_COUNT;
                        end else begin
                           rsp_valid_ff <= 1'b1;
                           rsp_kind_ff  <= mdq_pkg::KIND_ACK;
                        end
                     end
                     mdq_pkg::MODE_DISABLE: begin
                        all_ff   <= 1'b1;
                        has_ff   <= 1'b1;
                        state_ff <= S_COUNT;
                     end
                     mdq_pkg::MODE_ENABLE: begin
                        enabled_ff   <= 1'b1;
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= mdq_pkg::KIND_ACK;
                     end
                     default: begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= mdq_pkg::KIND_ACK;
                     end
                  endcase
               end
            end
            S_ISSUE: begin
               if (rd_ff == count_ff) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= mdq_pkg::KIND_NONE;
                  rsp_count_ff <= count_ff;
                  state_ff     <= S_IDLE;
               end else if (mres.blocked) begin
                  if (cur_ent.blocking) begin
                     ba_ff <= ba_ff || cur_ent.audio;
                     bv_ff <= bv_ff || cur_ent.visual;
                  end
                  rd_ff <= rd_next;
               end else begin
                  if (cur_ent.blocking && cur_ent.audio) begin
                     a_valid_ff <= 1'b1;
                     a_id_ff    <= cur_ent.id;
                     a_tag_ff   <= cur_ent.tag;
                     a_has_ff   <= cur_ent.has_tag;
                  end
                  if (cur_ent.blocking && cur_ent.visual) begin
                     v_valid_ff <= 1'b1;
                     v_id_ff    <= cur_ent.id;
                     v_tag_ff   <= cur_ent.tag;
                     v_has_ff   <= cur_ent.has_tag;
                  end
                  rsp_id_ff <= cur_ent.id;
                  state_ff  <= S_SHIFT;
               end
            end
            S_SHIFT: begin
               if (rd_next < count_ff) begin
                  store_ff[rd_ff[XW-1:0]] <= store_ff[rd_next[XW-1:0]];
                  rd_ff <= rd_next;
               end else begin
                  count_ff     <= count_ff - 1'b1;
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= mdq_pkg::KIND_ISSUED;
                  rsp_count_ff <= count_ff - 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            S_REMOVE: begin
               if (rd_ff == count_ff) begin
                  count_ff <= wr_ff;
                  rd_ff    <= '0;
                  if (mode_ff == mdq_pkg::MODE_FAIL) begin
                     has_ff   <= new_has_ff;
                     tag_ff   <= new_tag_ff;
                     state_ff <= S_COUNT;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= mdq_pkg::KIND_ACK;
                     rsp_count_ff <= wr_ff;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  if (!mres.id_hit) begin
                     store_ff[wr_ff[XW-1:0]] <= cur_ent;
                     wr_ff <= wr_ff + 1'b1;
                  end
                  rd_ff <= rd_next;
               end
            end
            S_COUNT: begin
               if (!has_ff) begin
                  if (mode_ff == mdq_pkg::MODE_SET_TAG) begin
                     grp_present_ff <= new_has_ff;
                     grp_tag_ff     <= new_tag_ff;
                  end
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= mdq_pkg::KIND_ACK;
                  rsp_count_ff <= count_ff;
                  state_ff     <= S_IDLE;
               end else if (rd_ff == count_ff) begin
                  removed_ff <= count_ff - surv_ff;
                  rd_ff      <= '0;
                  wr_ff      <= '0;
                  state_ff   <= S_HOLD_A;
               end else begin
                  if (!mres.scrub_hit) surv_ff <= surv_ff + 1'b1;
                  rd_ff <= rd_next;
               end
            end
            S_HOLD_A: begin
               freed_a_ff <= a_hit;
               aid_ff     <= a_id_ff;
               if (a_hit) begin
                  a_valid_ff   <= 1'b0;
                  any_ff       <= 1'b1;
                  rsp_valid_ff <= 1'b1;
                  rsp_kind_ff  <= mdq_pkg::KIND_CANCEL;
                  rsp_id_ff    <= a_id_ff;
                  rsp_last_ff  <= !v_cancel && removed_ff == '0;
                  rsp_count_ff <= surv_ff;
               end
               state_ff <= S_HOLD_V;
            end
            S_HOLD_V: begin
               if (v_hit) begin
                  v_valid_ff <= 1'b0;
                  if (!(freed_a_ff && v_id_ff == aid_ff)) begin
                     any_ff       <= 1'b1;
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= mdq_pkg::KIND_CANCEL;
                     rsp_id_ff    <= v_id_ff;
                     rsp_last_ff  <= removed_ff == '0;
                     rsp_count_ff <= surv_ff;
                  end
               end
               state_ff <= S_SCRUB;
            end
            S_SCRUB: begin
               if (rd_ff == count_ff) begin
                  count_ff <= wr_ff;
                  if (mode_ff == mdq_pkg::MODE_SET_TAG) begin
                     grp_present_ff <= new_has_ff;
                     grp_tag_ff     <= new_tag_ff;
                  end else if (all_ff || (grp_present_ff && grp_tag_ff == tag_ff)) begin
                     grp_present_ff <= 1'b0;
                     grp_tag_ff     <= '0;
                  end
                  if (mode_ff == mdq_pkg::MODE_DISABLE) enabled_ff <= 1'b0;
                  if (!any_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= mdq_pkg::KIND_ACK;
                     rsp_id_ff    <= '0;
                     rsp_last_ff  <= 1'b1;
                     rsp_count_ff <= wr_ff;
                  end
                  state_ff <= S_IDLE;
               end else begin
                  if (mres.scrub_hit) begin
                     any_ff       <= 1'b1;
                     removed_ff   <= removed_ff - 1'b1;
                     rsp_valid_ff <= 1'b1;
                     rsp_kind_ff  <= mdq_pkg::KIND_CANCEL;
                     rsp_id_ff    <= cur_ent.id;
                     rsp_last_ff  <= removed_ff == CW'(1);
                     rsp_count_ff <= surv_ff;
                  end else begin
                     store_ff[wr_ff[XW-1:0]] <= cur_ent;
                     wr_ff <= wr_ff + 1'b1;
                  end
                  rd_ff <= rd_next;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign busy            = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_out_id      = rsp_id_ff;
   assign rsp_last        = rsp_last_ff;
   assign rsp_queue_count = 5'(rsp_count_ff);

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(mdq_pkg::QUEUE_DEPTH))
      else $error("queue count above depth");
   a_more_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> busy)
      else $error("non-final beat with sequencer idle");
   a_scrub_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCRUB) |-> (wr_ff <= rd_ff && rd_ff <= count_ff))
      else $error("scrub pointers out of order");
   a_issue_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == mdq_pkg::KIND_ISSUED) |-> $past(state_ff == S_SHIFT))
      else $error("issue beat outside shift step");
`endif

endmodule
